FILE: hw/rtl/osq_pkg.sv
// ----------------------------------------------------------------------------
// osq_pkg
// Shared types and constants of the ordered sequence store.
// ----------------------------------------------------------------------------
package osq_pkg;

  localparam int DEF_CAPACITY    = 16;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam int FIELD_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;
  localparam int ACTION_W = 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND  = 3'd0,
    ACT_PREPEND = 3'd1,
    ACT_INSERT  = 3'd2,
    ACT_REMOVE  = 3'd3,
    ACT_CLEAR   = 3'd4,
    ACT_SORT    = 3'd5,
    ACT_SHOW    = 3'd6
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS,
    S_RMV,
    S_SORT,
    S_SUM,
    S_DIV,
    S_FIN,
    S_SHOW_RD,
    S_SHOW_WR
  } seq_state_t;

endpackage

FILE: hw/rtl/osq_if.sv
// ----------------------------------------------------------------------------
// osq_if
// Request and result channels of the ordered sequence store.
// ----------------------------------------------------------------------------
interface osq_in_if;
  logic                                valid;
  logic                                ready;
  logic [osq_pkg::ACTION_W-1:0]        action;
  logic signed [osq_pkg::FIELD_W-1:0]  operand_value;

  modport source(output valid, action, operand_value, input ready);
  modport sink(input valid, action, operand_value, output ready);
endinterface

interface osq_out_if;
  logic                                valid;
  logic                                ready;
  logic [osq_pkg::STATUS_W-1:0]        status;
  logic signed [osq_pkg::FIELD_W-1:0]  element;
  logic [osq_pkg::COUNT_W-1:0]         entry_count;
  logic signed [osq_pkg::FIELD_W-1:0]  smallest;
  logic signed [osq_pkg::FIELD_W-1:0]  largest;
  logic signed [osq_pkg::FIELD_W-1:0]  average;
  logic                                last_of_run;

  modport source(output valid, status, element, entry_count, smallest, largest,
                 average, last_of_run, input ready);
  modport sink(input valid, status, element, entry_count, smallest, largest,
               average, last_of_run, output ready);
endinterface

FILE: hw/rtl/osq_div.sv
// ----------------------------------------------------------------------------
// osq_div
// Restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module osq_div #(
  parameter int DW = 37,
  parameter int CW = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [DW-1:0] dividend,
  input  logic [CW-1:0]        divisor,
  output logic                 done,
  output logic signed [DW-1:0] quotient
);

  localparam int IW = $clog2(DW + 1);

  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [CW-1:0] dsr_r, dsr_nxt;
  logic [IW-1:0] it_r, it_nxt;
  logic [CW:0]   rem_sh;
  logic [CW:0]   rem_sub;
  logic          fits;

  assign rem_sh  = {rem_r, quo_r[DW-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_r};
  assign fits    = (rem_sh >= {1'b0, dsr_r});

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    it_nxt   = it_r;
    if (start) begin
      run_nxt = 1'b1;
      neg_nxt = dividend[DW-1];
      quo_nxt = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
      rem_nxt = '0;
      dsr_nxt = divisor;
      it_nxt  = '0;
    end else if (run_r) begin
      // shift one dividend bit in, subtract when the divisor fits
      rem_nxt = fits ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
      quo_nxt = {quo_r[DW-2:0], fits};
      it_nxt  = it_r + 1'b1;
      if (it_r == IW'(DW - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    it_r  <= it_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? -signed'(quo_r) : signed'(quo_r);

endmodule

FILE: hw/rtl/ordered_sequence_store_core.sv
// ----------------------------------------------------------------------------
// ordered_sequence_store_core
// Ordered list of signed words with insert, remove, sort, clear and show.
// ----------------------------------------------------------------------------
// With N entries held, every request ends with a summary pass and, when N > 0,
//   a divide of the SW = VALUE_WIDTH + clog2(CAPACITY+1) bit running sum;
//   insert and remove add one pass, sort adds up to N passes.
//   Show reads each next entry only after the previous result has been taken.
//   One request is in work at a time.
// Reset clears the sequencer, the count and the result valid flag; the entry
// memory is not cleared and only entries below the count are ever read.
// ----------------------------------------------------------------------------
module ordered_sequence_store_core #(
  parameter int CAPACITY    = osq_pkg::DEF_CAPACITY,
  parameter int VALUE_WIDTH = osq_pkg::DEF_VALUE_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  osq_in_if.sink    in_req,
  osq_out_if.source out_rsp
);

  localparam int CW = $clog2(CAPACITY + 1);   // count, can hold CAPACITY
  localparam int AW = $clog2(CAPACITY);       // entry index
  localparam int VW = VALUE_WIDTH;
  localparam int SW = VW + CW;                // running sum
  localparam int FW = osq_pkg::FIELD_W;
  localparam int KW = osq_pkg::COUNT_W;

  // Entry memory: one write and one registered read per cycle
  logic signed [VW-1:0] mem [CAPACITY];
  logic signed [VW-1:0] rd_data_r;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic signed [VW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Sequencer state
  osq_pkg::seq_state_t  state_r, state_nxt;
  osq_pkg::action_t     act_r, act_nxt;
  osq_pkg::status_t     st_r, st_nxt;
  logic signed [VW-1:0] v_r, v_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        rd_i_r, rd_i_nxt;
  logic                 pend_r, pend_nxt;
  logic [AW-1:0]        pend_idx_r, pend_idx_nxt;
  logic signed [VW-1:0] carry_r, carry_nxt;
  logic                 flag_r, flag_nxt;   // inserting, found, or swapped
  logic signed [VW-1:0] mn_r, mn_nxt;
  logic signed [VW-1:0] mx_r, mx_nxt;
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic signed [VW-1:0] avg_r, avg_nxt;

  // Result register
  logic                 ov_r, ov_nxt;
  osq_pkg::status_t     o_st_r, o_st_nxt;
  logic signed [FW-1:0] o_el_r, o_el_nxt;
  logic [KW-1:0]        o_cnt_r, o_cnt_nxt;
  logic signed [FW-1:0] o_mn_r, o_mn_nxt;
  logic signed [FW-1:0] o_mx_r, o_mx_nxt;
  logic signed [FW-1:0] o_avg_r, o_avg_nxt;
  logic                 o_last_r, o_last_nxt;

  // Divider
  logic                 div_start;
  logic                 div_done;
  logic signed [SW-1:0] div_q;

  osq_div #(
    .DW(SW),
    .CW(CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_q)
  );

  logic             accept;
  logic             out_free;
  logic             scan_done;
  logic             full;
  logic             empty;
  osq_pkg::action_t in_act;
  logic             show_last;

  assign in_req.ready = (state_r == osq_pkg::S_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign in_act       = osq_pkg::action_t'(in_req.action);
  assign out_free     = !ov_r || out_rsp.ready;
  assign scan_done    = (rd_i_r == cnt_r) && !pend_r;
  assign full         = (cnt_r == CW'(CAPACITY));
  assign empty        = (cnt_r == '0);
  assign show_last    = ((CW'(pend_idx_r) + 1'b1) == cnt_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      osq_pkg::S_IDLE: begin
        if (accept) begin
          priority case (in_act)
            osq_pkg::ACT_APPEND, osq_pkg::ACT_PREPEND, osq_pkg::ACT_INSERT:
              state_nxt = full ? osq_pkg::S_SUM : osq_pkg::S_INS;
            osq_pkg::ACT_REMOVE: state_nxt = empty ? osq_pkg::S_SUM : osq_pkg::S_RMV;
            osq_pkg::ACT_SORT:   state_nxt = empty ? osq_pkg::S_SUM : osq_pkg::S_SORT;
            default:             state_nxt = osq_pkg::S_SUM;
          endcase
        end
      end
      osq_pkg::S_INS, osq_pkg::S_RMV: begin
        if (scan_done) state_nxt = osq_pkg::S_SUM;
      end
      osq_pkg::S_SORT: begin
        if (scan_done && !flag_r) state_nxt = osq_pkg::S_SUM;
      end
      osq_pkg::S_SUM: begin
        if (scan_done) state_nxt = empty ? osq_pkg::S_FIN : osq_pkg::S_DIV;
      end
      osq_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = (act_r == osq_pkg::ACT_SHOW) ? osq_pkg::S_SHOW_RD : osq_pkg::S_FIN;
        end
      end
      osq_pkg::S_FIN: begin
        if (out_free) state_nxt = osq_pkg::S_IDLE;
      end
      osq_pkg::S_SHOW_RD: begin
        if (!ov_r) state_nxt = osq_pkg::S_SHOW_WR;
      end
      osq_pkg::S_SHOW_WR: begin
        state_nxt = show_last ? osq_pkg::S_IDLE : osq_pkg::S_SHOW_RD;
      end
      default: state_nxt = osq_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    act_nxt      = act_r;
    st_nxt       = st_r;
    v_nxt        = v_r;
    cnt_nxt      = cnt_r;
    rd_i_nxt     = rd_i_r;
    carry_nxt    = carry_r;
    flag_nxt     = flag_r;
    mn_nxt       = mn_r;
    mx_nxt       = mx_r;
    sum_nxt      = sum_r;
    avg_nxt      = avg_r;
    rd_en        = 1'b0;
    rd_addr      = rd_i_r[AW-1:0];
    wr_en        = 1'b0;
    wr_addr      = pend_idx_r;
    wr_data      = carry_r;
    div_start    = 1'b0;
    ov_nxt       = ov_r && !out_rsp.ready;
    o_st_nxt     = o_st_r;
    o_el_nxt     = o_el_r;
    o_cnt_nxt    = o_cnt_r;
    o_mn_nxt     = o_mn_r;
    o_mx_nxt     = o_mx_r;
    o_avg_nxt    = o_avg_r;
    o_last_nxt   = o_last_r;

    // the scanning states stream reads ahead of the processing step
    if ((state_r == osq_pkg::S_INS || state_r == osq_pkg::S_RMV ||
         state_r == osq_pkg::S_SORT || state_r == osq_pkg::S_SUM) &&
        (rd_i_r < cnt_r)) begin
      rd_en    = 1'b1;
      rd_i_nxt = rd_i_r + 1'b1;
    end

    unique case (state_r)
      osq_pkg::S_IDLE: begin
        if (accept) begin
          act_nxt  = in_act;
          v_nxt    = in_req.operand_value[VW-1:0];
          flag_nxt = 1'b0;
          rd_i_nxt = '0;
          priority case (in_act)
            osq_pkg::ACT_APPEND, osq_pkg::ACT_PREPEND, osq_pkg::ACT_INSERT: begin
              st_nxt = full ? osq_pkg::STAT_FULL : osq_pkg::STAT_OK;
              // append skips the walk and goes straight to the tail
              if (in_act == osq_pkg::ACT_APPEND && !full) rd_i_nxt = cnt_r;
            end
            osq_pkg::ACT_CLEAR: begin
              st_nxt  = empty ? osq_pkg::STAT_EMPTY : osq_pkg::STAT_OK;
              cnt_nxt = '0;
            end
            default: st_nxt = empty ? osq_pkg::STAT_EMPTY : osq_pkg::STAT_OK;
          endcase
        end
      end

      osq_pkg::S_INS: begin
        if (pend_r) begin
          if (flag_r) begin
            // ripple the displaced entry one place up
            wr_en     = 1'b1;
            wr_data   = carry_r;
            carry_nxt = rd_data_r;
          end else if (act_r == osq_pkg::ACT_PREPEND ||
                       (act_r == osq_pkg::ACT_INSERT && rd_data_r >= v_r)) begin
            wr_en     = 1'b1;
            wr_data   = v_r;
            carry_nxt = rd_data_r;
            flag_nxt  = 1'b1;
          end
        end else if (scan_done) begin
          wr_en    = 1'b1;
          wr_addr  = cnt_r[AW-1:0];
          wr_data  = flag_r ? carry_r : v_r;
          cnt_nxt  = cnt_r + 1'b1;
          rd_i_nxt = '0;
        end
      end

      osq_pkg::S_RMV: begin
        if (pend_r) begin
          if (flag_r) begin
            // close the gap left by the removed entry
            wr_en   = 1'b1;
            wr_addr = pend_idx_r - 1'b1;
            wr_data = rd_data_r;
          end else if (rd_data_r == v_r) begin
            flag_nxt = 1'b1;
          end
        end else if (scan_done) begin
          if (flag_r) cnt_nxt = cnt_r - 1'b1;
          else        st_nxt  = osq_pkg::STAT_NOT_FOUND;
          rd_i_nxt = '0;
        end
      end

      osq_pkg::S_SORT: begin
        // one bubble pass: carry the larger value, drop the smaller behind
        if (pend_r) begin
          if (pend_idx_r == '0) begin
            carry_nxt = rd_data_r;
          end else begin
            wr_en   = 1'b1;
            wr_addr = pend_idx_r - 1'b1;
            if (carry_r > rd_data_r) begin
              wr_data  = rd_data_r;
              flag_nxt = 1'b1;
            end else begin
              wr_data   = carry_r;
              carry_nxt = rd_data_r;
            end
          end
        end else if (scan_done) begin
          wr_en    = 1'b1;
          wr_addr  = AW'(cnt_r - 1'b1);
          wr_data  = carry_r;
          flag_nxt = 1'b0;
          rd_i_nxt = '0;
        end
      end

      osq_pkg::S_SUM: begin
        if (pend_r) begin
          if (pend_idx_r == '0) begin
            mn_nxt  = rd_data_r;
            mx_nxt  = rd_data_r;
            sum_nxt = SW'(rd_data_r);
          end else begin
            if (rd_data_r < mn_r) mn_nxt = rd_data_r;
            if (rd_data_r > mx_r) mx_nxt = rd_data_r;
            sum_nxt = sum_r + SW'(rd_data_r);
          end
        end else if (scan_done) begin
          if (empty) begin
            mn_nxt  = '0;
            mx_nxt  = '0;
            avg_nxt = '0;
          end else begin
            div_start = 1'b1;
          end
        end
      end

      osq_pkg::S_DIV: begin
        if (div_done) begin
          avg_nxt  = div_q[VW-1:0];
          rd_i_nxt = '0;
        end
      end

      osq_pkg::S_FIN: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          o_st_nxt   = st_r;
          o_el_nxt   = '0;
          o_cnt_nxt  = KW'(cnt_r);
          o_mn_nxt   = FW'(mn_r);
          o_mx_nxt   = FW'(mx_r);
          o_avg_nxt  = FW'(avg_r);
          o_last_nxt = 1'b1;
        end
      end

      osq_pkg::S_SHOW_RD: begin
        // hold the read until the result register has drained
        if (!ov_r) begin
          rd_en    = 1'b1;
          rd_i_nxt = rd_i_r + 1'b1;
        end
      end

      osq_pkg::S_SHOW_WR: begin
        ov_nxt     = 1'b1;
        o_st_nxt   = st_r;
        o_el_nxt   = FW'(rd_data_r);
        o_cnt_nxt  = KW'(cnt_r);
        o_mn_nxt   = FW'(mn_r);
        o_mx_nxt   = FW'(mx_r);
        o_avg_nxt  = FW'(avg_r);
        o_last_nxt = show_last;
      end

      default: begin
      end
    endcase
  end

  assign pend_nxt     = rd_en;
  assign pend_idx_nxt = rd_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= osq_pkg::S_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
    act_r      <= act_nxt;
    st_r       <= st_nxt;
    v_r        <= v_nxt;
    rd_i_r     <= rd_i_nxt;
    pend_idx_r <= pend_idx_nxt;
    carry_r    <= carry_nxt;
    flag_r     <= flag_nxt;
    mn_r       <= mn_nxt;
    mx_r       <= mx_nxt;
    sum_r      <= sum_nxt;
    avg_r      <= avg_nxt;
    o_st_r     <= o_st_nxt;
    o_el_r     <= o_el_nxt;
    o_cnt_r    <= o_cnt_nxt;
    o_mn_r     <= o_mn_nxt;
    o_mx_r     <= o_mx_nxt;
    o_avg_r    <= o_avg_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_rsp.valid       = ov_r;
  assign out_rsp.status      = o_st_r;
  assign out_rsp.element     = o_el_r;
  assign out_rsp.entry_count = o_cnt_r;
  assign out_rsp.smallest    = o_mn_r;
  assign out_rsp.largest     = o_mx_r;
  assign out_rsp.average     = o_avg_r;
  assign out_rsp.last_of_run = o_last_r;

endmodule
